// ===== rtl/pets_pkg.sv =====
package pets_pkg;

    localparam int ENTRIES_DEF = 32;

    localparam int ID_W    = 22;
    localparam int TS_W    = 40;
    localparam int WIN_W   = 32;
    localparam int CNT_W   = 8;
    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 5;
    localparam int INDEX_W = 8;
    localparam int DATA_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Register indexes on the configuration port.
    localparam logic [INDEX_W-1:0] REG_MODE      = 8'd0;
    localparam logic [INDEX_W-1:0] REG_WATCH     = 8'd1;
    localparam logic [INDEX_W-1:0] REG_WINDOW    = 8'd2;
    localparam logic [INDEX_W-1:0] REG_THRESHOLD = 8'd3;

    // Reset values of the registers.
    localparam logic [MODE_W-1:0] MODE_RST      = 2'd1;
    localparam logic              WATCH_RST     = 1'b1;
    localparam logic [WIN_W-1:0]  WINDOW_RST    = 32'd300000;
    localparam logic [CNT_W-1:0]  THRESHOLD_RST = 8'd8;

    // One table entry as it is kept in the entry memory.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TS_W-1:0]  wstart;
        logic [CNT_W-1:0] count;
    } t_entry;

    // One result word.
    typedef struct packed {
        logic              noted;
        logic [SLOT_W-1:0] slot;
        logic              new_entry;
        logic              window_restarted;
        logic [CNT_W-1:0]  count_now;
        logic              storm;
        logic              kill_request;
    } t_result;

    // Operand pair and outcome of the shared subtract/compare unit.
    typedef struct packed {
        logic [TS_W-1:0] a;
        logic [TS_W-1:0] b;
    } t_alu_in;

    typedef struct packed {
        logic [TS_W-1:0] diff;
        logic            lt;
    } t_alu_out;

endpackage

// ===== rtl/pets_ram.sv =====
module pets_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pets_alu.sv =====
module pets_alu (
    input  pets_pkg::t_alu_in  i_op,
    output pets_pkg::t_alu_out o_res
);

    logic [pets_pkg::TS_W:0] w_sub;

    // The borrow out of a - b tells that a is below b, unsigned.
    assign w_sub      = {1'b0, i_op.a} - {1'b0, i_op.b};
    assign o_res.diff = w_sub[pets_pkg::TS_W-1:0];
    assign o_res.lt   = w_sub[pets_pkg::TS_W];

endmodule

// ===== rtl/per_id_event_storm_tracker.sv =====
// Channel   Direction  Handshake                 Word
// input     in         i_valid / o_stall         i_proc_id, i_now_ms, i_is_oops
// result    out        o_valid / i_stall         o_noted, o_slot, o_new_entry,
//                                                o_window_restarted, o_count_now,
//                                                o_storm, o_kill_request
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A counted word goes from acceptance to the result register in steps: the scan
// streams the entry memory through its single registered read port, one entry a
// cycle, then two steps reuse the same 40-bit subtract/compare unit and a third
// writes the entry back. A word that is not counted skips these steps and goes
// straight to the done state. o_stall stays high from acceptance until the result
// has been loaded into the output register; a full output register that is held
// by i_stall delays that load. Reset (synchronous, active low) restores the
// configuration and control registers and marks every entry as empty, so that it
// reads as all zero.
module per_id_event_storm_tracker #(
    parameter int ENTRIES = pets_pkg::ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel.
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [pets_pkg::ID_W-1:0]      i_proc_id,
    input  logic [pets_pkg::TS_W-1:0]      i_now_ms,
    input  logic                           i_is_oops,
    // Result channel.
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_noted,
    output logic [pets_pkg::SLOT_W-1:0]    o_slot,
    output logic                           o_new_entry,
    output logic                           o_window_restarted,
    output logic [pets_pkg::CNT_W-1:0]     o_count_now,
    output logic                           o_storm,
    output logic                           o_kill_request,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pets_pkg::INDEX_W-1:0]   i_cfg_index,
    input  logic [pets_pkg::DATA_W-1:0]    i_cfg_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int EW = $bits(pets_pkg::t_entry);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_ELAP = 6'b000100,
        S_WIN  = 6'b001000,
        S_UPD  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [pets_pkg::MODE_W-1:0] r_mode;
    logic                        r_watch;
    logic [pets_pkg::WIN_W-1:0]  r_window;
    logic [pets_pkg::CNT_W-1:0]  r_threshold;

    // Captured input word.
    logic [pets_pkg::ID_W-1:0]   r_pid;
    logic [pets_pkg::TS_W-1:0]   r_now;

    // Scan control.
    logic [IW-1:0]               r_ridx;
    logic                        r_iss_done;
    logic                        r_pend;
    logic [IW-1:0]               r_cidx;
    logic [IW-1:0]               r_old;
    logic [pets_pkg::TS_W-1:0]   r_old_ws;

    // Chosen entry and its working values.
    logic [IW-1:0]               r_slot;
    logic [pets_pkg::TS_W-1:0]   r_ws;
    logic [pets_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_fresh;
    logic [pets_pkg::TS_W-1:0]   r_elapsed;
    logic                        r_restart;

    // Entry valid bits: an entry never written reads as all zero.
    logic [ENTRIES-1:0]          r_valid;

    pets_pkg::t_result           r_res;
    pets_pkg::t_result           r_out;
    logic                        r_o_valid;

    pets_pkg::t_entry            w_rd;
    pets_pkg::t_entry            w_ent;
    pets_pkg::t_entry            w_wr;
    logic [EW-1:0]               w_rdata;
    logic                        w_we;
    pets_pkg::t_alu_in           w_alu_in;
    pets_pkg::t_alu_out          w_alu_out;
    logic                        w_in_acc;
    logic                        w_out_free;
    logic                        w_hit;
    logic [pets_pkg::CNT_W-1:0]  w_cnt0;
    logic [pets_pkg::CNT_W-1:0]  w_cnt;
    logic                        w_storm;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;

    // Entry memory: id, window start and count packed into one word.
    pets_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot),
        .i_wdata (w_wr),
        .i_raddr (r_ridx),
        .o_rdata (w_rdata)
    );

    assign w_rd  = pets_pkg::t_entry'(w_rdata);
    assign w_ent = r_valid[r_cidx] ? w_rd : '0;
    assign w_hit = r_pend && (w_ent.id == r_pid);

    // The shared unit compares window starts during the scan, then forms the
    // elapsed time, then compares it against the window length.
    always_comb begin
        case (r_state)
            S_SCAN: begin
                w_alu_in.a = w_ent.wstart;
                w_alu_in.b = r_old_ws;
            end
            S_WIN: begin
                w_alu_in.a = {{(pets_pkg::TS_W - pets_pkg::WIN_W){1'b0}}, r_window};
                w_alu_in.b = r_elapsed;
            end
            default: begin
                w_alu_in.a = r_now;
                w_alu_in.b = r_ws;
            end
        endcase
    end

    pets_alu u_alu (
        .i_op  (w_alu_in),
        .o_res (w_alu_out)
    );

    // Count update: a restarted window starts from zero, the increment
    // saturates, and a storm clears the stored count.
    assign w_cnt0  = r_restart ? '0 : r_cnt;
    assign w_cnt   = (w_cnt0 == pets_pkg::CNT_MAX) ? pets_pkg::CNT_MAX
                                                   : w_cnt0 + 1'b1;
    assign w_storm = (w_cnt >= r_threshold);

    assign w_we         = (r_state == S_UPD);
    assign w_wr.id      = r_pid;
    assign w_wr.wstart  = r_restart ? r_now : r_ws;
    assign w_wr.count   = w_storm ? '0 : w_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= pets_pkg::MODE_RST;
            r_watch     <= pets_pkg::WATCH_RST;
            r_window    <= pets_pkg::WINDOW_RST;
            r_threshold <= pets_pkg::THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pets_pkg::REG_MODE:      r_mode      <= i_cfg_data[pets_pkg::MODE_W-1:0];
                pets_pkg::REG_WATCH:     r_watch     <= i_cfg_data[0];
                pets_pkg::REG_WINDOW:    r_window    <= i_cfg_data[pets_pkg::WIN_W-1:0];
                pets_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data[pets_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_o_valid  <= 1'b0;
            r_pend     <= 1'b0;
            r_iss_done <= 1'b0;
            r_ridx     <= '0;
        end else begin
            // A new result loads the output register; otherwise a taken one
            // empties it.
            if (r_state == S_DONE && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_ridx     <= '0;
                        r_iss_done <= 1'b0;
                        r_pend     <= 1'b0;
                        if (r_watch && i_is_oops) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (!r_iss_done) begin
                        r_ridx <= r_ridx + 1'b1;
                        if (r_ridx == LAST) begin
                            r_iss_done <= 1'b1;
                        end
                    end
                    if (r_pend && (w_hit || r_cidx == LAST)) begin
                        r_state <= S_ELAP;
                        r_pend  <= 1'b0;
                    end else begin
                        r_pend <= !r_iss_done;
                    end
                end
                S_ELAP: begin
                    r_state <= S_WIN;
                end
                S_WIN: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_valid[r_slot] <= 1'b1;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_pid <= i_proc_id;
                r_now <= i_now_ms;
                r_res <= '0;
            end
            S_SCAN: begin
                if (!r_iss_done) begin
                    r_cidx <= r_ridx;
                end
                if (r_pend) begin
                    if (w_hit) begin
                        r_slot  <= r_cidx;
                        r_ws    <= w_ent.wstart;
                        r_cnt   <= w_ent.count;
                        r_fresh <= 1'b0;
                    end else begin
                        // Track the oldest window start, lowest index on ties.
                        if (r_cidx == '0 || w_alu_out.lt) begin
                            r_old    <= r_cidx;
                            r_old_ws <= w_ent.wstart;
                        end
                        if (r_cidx == LAST) begin
                            r_slot  <= (r_cidx == '0 || w_alu_out.lt) ? r_cidx : r_old;
                            r_ws    <= r_now;
                            r_cnt   <= '0;
                            r_fresh <= 1'b1;
                        end
                    end
                end
            end
            S_ELAP: begin
                r_elapsed <= w_alu_out.diff;
            end
            S_WIN: begin
                // The window length lies below the elapsed time.
                r_restart <= w_alu_out.lt;
            end
            S_UPD: begin
                r_res.noted            <= 1'b1;
                r_res.slot             <= pets_pkg::SLOT_W'(r_slot);
                r_res.new_entry        <= r_fresh;
                r_res.window_restarted <= r_restart;
                r_res.count_now        <= w_cnt;
                r_res.storm            <= w_storm;
                r_res.kill_request     <= w_storm && (r_mode != '0);
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_cfg_ready        = 1'b1;
    assign o_valid            = r_o_valid;
    assign o_noted            = r_out.noted;
    assign o_slot             = r_out.slot;
    assign o_new_entry        = r_out.new_entry;
    assign o_window_restarted = r_out.window_restarted;
    assign o_count_now        = r_out.count_now;
    assign o_storm            = r_out.storm;
    assign o_kill_request     = r_out.kill_request;

`ifndef SYNTHESIS
    // A kill is only ever requested together with a storm.
    a_kill_needs_storm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_kill_request || o_storm))
        else $error("kill request without storm");

    // A word that was not counted carries an all-zero result.
    a_quiet_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_noted) |-> (o_slot == '0 && !o_new_entry &&
            !o_window_restarted && o_count_now == '0 && !o_storm))
        else $error("uncounted word has nonzero fields");

    // A counted word always reports a count of at least one.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_noted) |-> (o_count_now != '0))
        else $error("counted word with zero count");

    // The block takes one word at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while busy");
`endif

endmodule
